[src/gbf_pkg.sv]
`timescale 1ns / 1ps

package gbf_pkg;

    localparam int RATE_W  = 16;
    localparam int ELAP_W  = 16;
    localparam int CNT_W   = 10;
    localparam int SUM_W   = 26;
    localparam int Q_W     = 32;
    localparam int ANGLE_W = 48;
    localparam int FRAC_W  = 16;

    // dividend is |sum| scaled by 2^16
    localparam int DVD_W   = SUM_W + FRAC_W;
    // shift-add multiplier: signed multiplicand up to 33 bits shifted 15 places
    localparam int MUL_W   = 49;
    localparam int STEP_W  = 6;

    localparam int DIV_STEPS = DVD_W;
    localparam int MUL_STEPS = ELAP_W;

    localparam int WARMUP_DROPS = 2;

    localparam logic [CNT_W-1:0]  CALIB_RESET = 10'd500;
    localparam logic [ELAP_W-1:0] ALPHA_Q16   = 16'd9830;

    localparam logic [1:0] MODE_CALIB = 2'd1;
    localparam logic [1:0] MODE_EXEC  = 2'd2;

    localparam logic [7:0] REG_MODE  = 8'd0;
    localparam logic [7:0] REG_CALIB = 8'd1;

    localparam logic [2:0] STAT_WARMUP = 3'd0;
    localparam logic [2:0] STAT_ACCUM  = 3'd1;
    localparam logic [2:0] STAT_OFFSET = 3'd2;
    localparam logic [2:0] STAT_ANGLE  = 3'd3;
    localparam logic [2:0] STAT_IDLE   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_DIV_FIX,
        S_PREP,
        S_MUL_F,
        S_FILT,
        S_ASETUP,
        S_MUL_A,
        S_ANGLE,
        S_OUT
    } gbf_state_t;

endpackage

[src/gyro_bias_filter_integrator.sv]
`timescale 1ns / 1ps

// gyro z-axis bias calibration, rate filter and angle integrator
//
// input beats on s_axis carry one rate sample and the milliseconds since the
// previous sample; every input beat yields exactly one beat on m_axis.
// the cfg channel writes mode (index 0) and calib_samples (index 1); it is
// always ready and is meant to be written only while the block is idle.
//
// in idle mode, for warmup / accumulate samples and for an offset from a zero
// count the sample goes from S_DECIDE straight to S_OUT. in execute mode it
// runs two 16-step shift-add multiplies, filter then angle, and skips the
// filter multiply when the sample loads an empty filter. a calibration sample
// that recomputes the offset runs a 42-step restoring divider, one quotient
// bit per cycle. one sample is in flight at a time: no new input beat is
// taken until the last one's result has left the final state.
//
// reset clears the bias, filter, angle and calibration counters, sets mode
// to idle and calib_samples to 500. a stalled receiver holds the output
// register; the next input beat is still taken and worked on, and its
// result waits in the final state until the output register frees up.

module gyro_bias_filter_integrator
    import gbf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] rate_z, [31:16] elapsed_ms
    input  logic [31:0]  s_axis_tdata,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] rate_filtered, [79:32] angle_acc, [111:80] bias_offset,
    // [112] calib_done, [113] saturated, [119:114] zero
    output logic [119:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]   m_axis_tuser,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    // control and architectural state
    gbf_state_t         state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [CNT_W-1:0]   calib_n_reg, calib_n_next;
    logic [1:0]         warm_reg, warm_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [Q_W-1:0]     offset_reg, offset_next;
    logic [Q_W-1:0]     filt_reg, filt_next;
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic               done_reg, done_next;
    logic               m_valid_reg, m_valid_next;

    // working registers
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [ELAP_W-1:0]  elapsed_reg, elapsed_next;
    logic [2:0]         status_reg, status_next;
    logic               sat_reg, sat_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic [MUL_W-1:0]   mcand_reg, mcand_next;
    logic [ELAP_W-1:0]  mplier_reg, mplier_next;
    logic [MUL_W-1:0]   prod_reg, prod_next;
    logic [119:0]       out_data_reg, out_data_next;
    logic [2:0]         out_user_reg, out_user_next;

    // helpers
    logic               warm_busy;
    logic               accum_open;
    logic               div_last;
    logic               mul_last;
    logic               out_free;
    logic [SUM_W-1:0]   sum_mag;
    logic [CNT_W:0]     div_shift;
    logic               div_qbit;
    logic [CNT_W:0]     div_diff;
    logic               q_ovf_pos;
    logic               q_ovf_neg;
    logic [Q_W:0]       x_wide;
    logic [Q_W-1:0]     x_sat;
    logic [Q_W:0]       d_wide;
    logic [MUL_W:0]     filt_sum;
    logic [MUL_W-FRAC_W:0] filt_shr;
    logic [Q_W-1:0]     filt_sat;
    logic [MUL_W-1:0]   angle_sum;

    assign warm_busy  = warm_reg < 2'(WARMUP_DROPS);
    assign accum_open = cnt_reg < calib_n_reg;
    assign div_last   = step_reg == STEP_W'(DIV_STEPS - 1);
    assign mul_last   = step_reg == STEP_W'(MUL_STEPS - 1);
    assign out_free   = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = state_reg == S_IDLE;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // divider: one restoring step per cycle
    assign sum_mag   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign div_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_qbit  = div_shift >= {1'b0, cnt_reg};
    assign div_diff  = div_shift - {1'b0, cnt_reg};
    assign q_ovf_pos = |dvd_reg[DVD_W-1:Q_W-1];
    assign q_ovf_neg = (|dvd_reg[DVD_W-1:Q_W]) || (dvd_reg[Q_W-1] && (|dvd_reg[Q_W-2:0]));

    // bias-corrected sample, saturated to 32 bits
    assign x_wide = {rate_reg[RATE_W-1], rate_reg, {FRAC_W{1'b0}}}
                  - {offset_reg[Q_W-1], offset_reg};
    assign x_sat  = (x_wide[Q_W] != x_wide[Q_W-1])
                  ? (x_wide[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}})
                  : x_wide[Q_W-1:0];
    assign d_wide = {x_sat[Q_W-1], x_sat} - {filt_reg[Q_W-1], filt_reg};

    // filter: f*65536 + alpha*(x - f) + half, floor shift by 16
    assign filt_sum = {prod_reg[MUL_W-1], prod_reg}
                    + {{2{filt_reg[Q_W-1]}}, filt_reg, {FRAC_W{1'b0}}}
                    + (MUL_W+1)'(32768);
    assign filt_shr = filt_sum[MUL_W:FRAC_W];
    assign filt_sat = (filt_shr[MUL_W-FRAC_W:Q_W-1] == {(MUL_W-FRAC_W-Q_W+2){1'b0}} ||
                       filt_shr[MUL_W-FRAC_W:Q_W-1] == {(MUL_W-FRAC_W-Q_W+2){1'b1}})
                    ? filt_shr[Q_W-1:0]
                    : (filt_shr[MUL_W-FRAC_W] ? {1'b1, {(Q_W-1){1'b0}}}
                                              : {1'b0, {(Q_W-1){1'b1}}});

    // angle plus rate times elapsed; the product fits 48 bits signed
    assign angle_sum = {angle_reg[ANGLE_W-1], angle_reg} + prod_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                case (mode_reg)
                    MODE_CALIB:
                    begin
                        if (warm_busy || accum_open || cnt_reg == '0)
                            state_next = S_OUT;
                        else
                            state_next = S_DIV;
                    end
                    MODE_EXEC:
                        state_next = S_PREP;
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_DIV:
            begin
                if (div_last)
                    state_next = S_DIV_FIX;
            end
            S_DIV_FIX:
                state_next = S_OUT;
            S_PREP:
            begin
                if (filt_reg == '0)
                    state_next = S_ASETUP;
                else
                    state_next = S_MUL_F;
            end
            S_MUL_F:
            begin
                if (mul_last)
                    state_next = S_FILT;
            end
            S_FILT:
                state_next = S_ASETUP;
            S_ASETUP:
                state_next = S_MUL_A;
            S_MUL_A:
            begin
                if (mul_last)
                    state_next = S_ANGLE;
            end
            S_ANGLE:
                state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next     = mode_reg;
        calib_n_next  = calib_n_reg;
        warm_next     = warm_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        offset_next   = offset_reg;
        filt_next     = filt_reg;
        angle_next    = angle_reg;
        done_next     = done_reg;
        rate_next     = rate_reg;
        elapsed_next  = elapsed_reg;
        status_next   = status_reg;
        sat_next      = sat_reg;
        step_next     = step_reg + 1'b1;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        m_valid_next  = m_axis_tready ? 1'b0 : m_valid_reg;

        if (cfg_valid)
        begin
            if (cfg_index == REG_MODE)
                mode_next = cfg_data[1:0];
            else if (cfg_index == REG_CALIB)
                calib_n_next = cfg_data[CNT_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                rate_next    = s_axis_tdata[RATE_W-1:0];
                elapsed_next = s_axis_tdata[RATE_W+ELAP_W-1:RATE_W];
            end
            S_DECIDE:
            begin
                sat_next    = 1'b0;
                status_next = STAT_IDLE;
                step_next   = '0;
                dvd_next    = {sum_mag, {FRAC_W{1'b0}}};
                rem_next    = '0;
                neg_next    = sum_reg[SUM_W-1];
                case (mode_reg)
                    MODE_CALIB:
                    begin
                        if (warm_busy)
                        begin
                            warm_next   = warm_reg + 1'b1;
                            status_next = STAT_WARMUP;
                        end
                        else if (accum_open)
                        begin
                            cnt_next    = cnt_reg + 1'b1;
                            sum_next    = sum_reg
                                        + {{(SUM_W-RATE_W){rate_reg[RATE_W-1]}}, rate_reg};
                            status_next = STAT_ACCUM;
                        end
                        else
                        begin
                            status_next = STAT_OFFSET;
                            if (cnt_reg == '0)
                            begin
                                offset_next = '0;
                                done_next   = 1'b1;
                            end
                        end
                    end
                    MODE_EXEC:
                        status_next = STAT_ANGLE;
                    default:
                        status_next = STAT_IDLE;
                endcase
            end
            S_DIV:
            begin
                dvd_next = {dvd_reg[DVD_W-2:0], div_qbit};
                rem_next = div_qbit ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
            end
            S_DIV_FIX:
            begin
                done_next = 1'b1;
                if (neg_reg)
                    offset_next = q_ovf_neg ? {1'b1, {(Q_W-1){1'b0}}}
                                            : (~dvd_reg[Q_W-1:0] + 1'b1);
                else
                    offset_next = q_ovf_pos ? {1'b0, {(Q_W-1){1'b1}}}
                                            : dvd_reg[Q_W-1:0];
            end
            S_PREP:
            begin
                step_next   = '0;
                prod_next   = '0;
                mplier_next = ALPHA_Q16;
                mcand_next  = {{(MUL_W-Q_W-1){d_wide[Q_W]}}, d_wide};
                if (filt_reg == '0)
                    filt_next = x_sat;
            end
            S_MUL_F, S_MUL_A:
            begin
                if (mplier_reg[0])
                    prod_next = prod_reg + mcand_reg;
                mcand_next  = {mcand_reg[MUL_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[ELAP_W-1:1]};
            end
            S_FILT:
                filt_next = filt_sat;
            S_ASETUP:
            begin
                step_next   = '0;
                prod_next   = '0;
                mplier_next = elapsed_reg;
                mcand_next  = {{(MUL_W-Q_W){filt_reg[Q_W-1]}}, filt_reg};
            end
            S_ANGLE:
            begin
                if (angle_sum[MUL_W-1] != angle_sum[ANGLE_W-1])
                begin
                    sat_next   = 1'b1;
                    angle_next = angle_sum[MUL_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                                    : {1'b0, {(ANGLE_W-1){1'b1}}};
                end
                else
                begin
                    angle_next = angle_sum[ANGLE_W-1:0];
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_user_next = status_reg;
                    out_data_next = {6'b0, sat_reg, done_reg, offset_reg, angle_reg, filt_reg};
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= '0;
            calib_n_reg <= CALIB_RESET;
            warm_reg    <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            offset_reg  <= '0;
            filt_reg    <= '0;
            angle_reg   <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            calib_n_reg <= calib_n_next;
            warm_reg    <= warm_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            offset_reg  <= offset_next;
            filt_reg    <= filt_next;
            angle_reg   <= angle_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg     <= rate_next;
        elapsed_reg  <= elapsed_next;
        status_reg   <= status_next;
        sat_reg      <= sat_next;
        step_reg     <= step_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule
